// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both expect signals named clk and rst
// in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// The condition must never be true outside reset.
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)

`endif

`endif

// ===== hdl/lrupr_pkg.sv =====
package lrupr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS = 16;
  localparam int SLOT_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int COUNT_BITS = $clog2(MAX_FRAMES + 1);

  // Fixed widths of the stream fields.
  localparam int CFG_BITS = 5;
  localparam int CFG_RESET = 16;
  localparam int PAGE_PORT_BITS = 16;
  localparam int SLOT_PORT_BITS = 4;
  localparam int TOTAL_BITS = 32;
  localparam int IN_TDATA_BITS = 16;
  localparam int OUT_TDATA_BITS = 88;
  localparam int OUT_TUSER_BITS = 3;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CFG_BITS-1:0] cfg_t;
  typedef logic [TOTAL_BITS-1:0] total_t;
  typedef logic [PAGE_PORT_BITS-1:0] port_page_t;
  typedef logic [SLOT_PORT_BITS-1:0] port_slot_t;

  // Outcome of one reference, from the frame table to the rest of the block.
  typedef struct packed {
    logic  hit;
    logic  fault;
    logic  filled;
    logic  full;
    slot_t slot;
    page_t evicted;
  } result_t;

  // A limit of zero acts as one frame, and a limit above the table size as
  // the whole table.
  function automatic count_t active_limit(cfg_t value);
    count_t limit;
    if (value == '0) begin
      limit = count_t'(1);
    end else if (int'(value) > MAX_FRAMES) begin
      limit = count_t'(MAX_FRAMES);
    end else begin
      limit = count_t'(value);
    end
    return limit;
  endfunction

endpackage

// ===== hdl/lrupr_table.sv =====
`include "assert_macros.svh"

module lrupr_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  lrupr_pkg::page_t    page,
  input  lrupr_pkg::count_t   limit,
  output lrupr_pkg::result_t  res
);

  lrupr_pkg::page_t  frame_page [lrupr_pkg::MAX_FRAMES];
  logic [lrupr_pkg::MAX_FRAMES-1:0] frame_valid;
  lrupr_pkg::slot_t  recency_rank [lrupr_pkg::MAX_FRAMES];
  lrupr_pkg::count_t filled_count;

  logic [lrupr_pkg::MAX_FRAMES-1:0] match;
  logic [lrupr_pkg::MAX_FRAMES-1:0] victim;
  logic [lrupr_pkg::MAX_FRAMES-1:0] age;
  lrupr_pkg::slot_t hit_idx;
  lrupr_pkg::slot_t victim_idx;
  lrupr_pkg::slot_t hit_rank;
  lrupr_pkg::slot_t oldest_rank;
  lrupr_pkg::slot_t rank_sel;
  logic hit;
  logic full;

  // Valid frames always hold ranks 0 to filled_count-1 exactly once, so the
  // least recent frame is the one whose rank equals filled_count-1.
  assign oldest_rank = lrupr_pkg::slot_t'(filled_count - lrupr_pkg::count_t'(1));
  assign full = (filled_count >= limit);

  always_comb begin
    hit_idx = '0;
    victim_idx = '0;
    hit_rank = '0;
    for (int k = 0; k < lrupr_pkg::MAX_FRAMES; k++) begin
      match[k] = frame_valid[k] && (frame_page[k] == page);
      victim[k] = frame_valid[k] && (recency_rank[k] == oldest_rank);
      if (match[k]) begin
        hit_rank = hit_rank | recency_rank[k];
      end
    end
    // Scan downward so that the lowest matching frame wins.
    for (int k = lrupr_pkg::MAX_FRAMES - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_idx = lrupr_pkg::slot_t'(k);
      end
      if (victim[k]) begin
        victim_idx = lrupr_pkg::slot_t'(k);
      end
    end
  end

  assign hit = |match;
  assign rank_sel = hit ? hit_rank : oldest_rank;

  always_comb begin
    res.hit = hit;
    res.full = full;
    res.filled = !hit && !full;
    res.fault = !hit && full;
    if (hit) begin
      res.slot = hit_idx;
    end else if (!full) begin
      res.slot = lrupr_pkg::slot_t'(filled_count);
    end else begin
      res.slot = victim_idx;
    end
    res.evicted = (!hit && full) ? frame_page[victim_idx] : '0;
  end

  // A fill ages every valid frame; a hit or a fault ages the frames more
  // recent than the one being promoted.
  always_comb begin
    for (int k = 0; k < lrupr_pkg::MAX_FRAMES; k++) begin
      age[k] = frame_valid[k] && (res.filled || (recency_rank[k] < rank_sel));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      filled_count <= '0;
      for (int k = 0; k < lrupr_pkg::MAX_FRAMES; k++) begin
        recency_rank[k] <= '0;
      end
    end else if (fire) begin
      for (int k = 0; k < lrupr_pkg::MAX_FRAMES; k++) begin
        if (lrupr_pkg::slot_t'(k) == res.slot) begin
          recency_rank[k] <= '0;
        end else if (age[k]) begin
          recency_rank[k] <= recency_rank[k] + lrupr_pkg::slot_t'(1);
        end
      end
      if (res.filled) begin
        frame_valid[res.slot] <= 1'b1;
        filled_count <= filled_count + lrupr_pkg::count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !hit) begin
      frame_page[res.slot] <= page;
    end
  end

  `ASSERT_CLK(a_valid_count, $countones(frame_valid) == int'(filled_count))
  `ASSERT_CLK(a_fault_only_full, res.fault |-> (res.full && !res.hit))
  `ASSERT_CLK(a_fill_grows, (fire && res.filled) |=>
              (filled_count == $past(filled_count) + lrupr_pkg::count_t'(1)))
  `ASSERT_NEVER(a_over_fill, int'(filled_count) > lrupr_pkg::MAX_FRAMES)

endmodule

// ===== hdl/lrupr_stats.sv =====
module lrupr_stats (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  lrupr_pkg::result_t res,
  output lrupr_pkg::total_t  fault_next,
  output lrupr_pkg::total_t  reference_next
);

  lrupr_pkg::total_t fault_counter;
  lrupr_pkg::total_t reference_counter;
  logic count_fault;
  logic count_reference;

  // Hits count as references only once the table is full; faults always do.
  assign count_fault = res.fault && (fault_counter != '1);
  assign count_reference = (res.fault || (res.hit && res.full)) && (reference_counter != '1);

  assign fault_next = count_fault ?
                      fault_counter + lrupr_pkg::total_t'(1) : fault_counter;
  assign reference_next = count_reference ?
                          reference_counter + lrupr_pkg::total_t'(1) : reference_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_counter <= '0;
      reference_counter <= '0;
    end else if (fire) begin
      fault_counter <= fault_next;
      reference_counter <= reference_next;
    end
  end

endmodule

// ===== hdl/lru_page_replacement.sv =====
// LRU frame table, fully associative over 16 frames of 16-bit page numbers.
// Each page reference on the s_ stream gives one result on the m_ stream: hit,
// fill of a free frame, or fault (replacement of the least recently used page),
// with the frame that now holds the page, the evicted page on a fault and
// saturating 32-bit fault and reference totals. References are counted only
// once all managed frames are full. One reference is taken per cycle while the
// m_ stream does not stall; the lookup, the victim choice and the recency update
// settle combinationally between the input register and the result register.
// cfg_data sets how many frames are managed (0 acts as 1, above 16 as 16); the
// user must write it only while the block is idle; the block does not enforce it.
module lru_page_replacement (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,   // frames_in_use
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // page_number
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,    // frame_slot, evicted_page, fault_total,
                                  // reference_total, zero fill
  output logic [2:0]  m_tuser     // hit, fault, filled
);

  lrupr_pkg::count_t  limit;
  logic               in_valid;
  lrupr_pkg::page_t   in_page;
  logic               fire;
  lrupr_pkg::result_t res;
  lrupr_pkg::total_t  fault_next;
  lrupr_pkg::total_t  reference_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= lrupr_pkg::active_limit(lrupr_pkg::cfg_t'(lrupr_pkg::CFG_RESET));
    end else if (cfg_valid) begin
      limit <= lrupr_pkg::active_limit(cfg_data);
    end
  end

  // The reference in the input register resolves when the result register
  // is free or being emptied in the same cycle.
  assign fire = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_page <= lrupr_pkg::page_t'(s_tdata);
    end
  end

  lrupr_table u_table (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .page  (in_page),
    .limit (limit),
    .res   (res)
  );

  lrupr_stats u_stats (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .res            (res),
    .fault_next     (fault_next),
    .reference_next (reference_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {4'b0000, reference_next, fault_next,
                  lrupr_pkg::port_page_t'(res.evicted),
                  lrupr_pkg::port_slot_t'(res.slot)};
      m_tuser <= {res.filled, res.fault, res.hit};
    end
  end

endmodule

// ===== tb/lru_tb_pkg.sv =====
package lru_tb_pkg;
  import lrupr_pkg::*;

  typedef struct packed {
    logic       hit;
    logic       fault;
    logic       filled;
    port_slot_t slot;
    port_page_t evicted;
    total_t     fault_total;
    total_t     reference_total;
  } page_outcome_t;

  // Tracks the frame table as the block should see it and holds the outcomes
  // still owed by the block, oldest first.
  class frame_table_model;
    port_page_t    frame_pages[MAX_FRAMES];
    bit            frame_used[MAX_FRAMES];
    int unsigned   age_rank[MAX_FRAMES];
    int unsigned   used_frames;
    total_t        fault_count;
    total_t        ref_count;
    cfg_t          frame_limit;
    page_outcome_t expected_outcomes[$];
    int unsigned   mismatches;
    int unsigned   hits_seen;
    int unsigned   fills_seen;
    int unsigned   faults_seen;

    function new();
      foreach (frame_pages[k]) begin
        frame_pages[k] = '0;
        frame_used[k] = 1'b0;
        age_rank[k] = 0;
      end
      used_frames = 0;
      fault_count = '0;
      ref_count = '0;
      frame_limit = cfg_t'(CFG_RESET);
      mismatches = 0;
      hits_seen = 0;
      fills_seen = 0;
      faults_seen = 0;
    endfunction

    function void set_limit(cfg_t value);
      frame_limit = value;
    endfunction

    function int unsigned managed_frames();
      if (frame_limit == '0) begin
        return 1;
      end
      if (int'(frame_limit) > MAX_FRAMES) begin
        return MAX_FRAMES;
      end
      return int'(frame_limit);
    endfunction

    function total_t bump(total_t value);
      return (value == '1) ? value : value + 1'b1;
    endfunction

    // Frames younger than the threshold age by one; idx becomes the newest.
    function void make_newest(int idx, int unsigned threshold);
      for (int k = 0; k < MAX_FRAMES; k++) begin
        if (frame_used[k] && k != idx && age_rank[k] < threshold) begin
          age_rank[k]++;
        end
      end
      age_rank[idx] = 0;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    function void note_reference(port_page_t pg);
      page_outcome_t want;
      int unsigned   limit;
      bit            full;
      int            found;
      int unsigned   oldest;
      want = '0;
      limit = managed_frames();
      full = (used_frames >= limit);
      found = -1;
      for (int k = 0; k < MAX_FRAMES; k++) begin
        if (found < 0 && frame_used[k] && frame_pages[k] == pg) begin
          found = k;
        end
      end
      if (found >= 0) begin
        want.hit = 1'b1;
        make_newest(found, age_rank[found]);
        if (full) begin
          ref_count = bump(ref_count);
        end
      end else if (!full) begin
        // Free frames are always taken in index order.
        found = int'(used_frames);
        frame_used[found] = 1'b1;
        frame_pages[found] = pg;
        age_rank[found] = MAX_FRAMES;
        make_newest(found, MAX_FRAMES);
        used_frames++;
        want.filled = 1'b1;
      end else begin
        // The victim is the oldest valid frame, even past a lowered limit.
        oldest = 0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
          if (frame_used[k] && (found < 0 || age_rank[k] > oldest)) begin
            found = k;
            oldest = age_rank[k];
          end
        end
        want.evicted = frame_pages[found];
        frame_pages[found] = pg;
        make_newest(found, age_rank[found]);
        want.fault = 1'b1;
        fault_count = bump(fault_count);
        ref_count = bump(ref_count);
      end
      want.slot = port_slot_t'(found);
      want.fault_total = fault_count;
      want.reference_total = ref_count;
      expected_outcomes = {expected_outcomes, want};
    endfunction

    function void check_outcome(logic [87:0] data, logic [2:0] user);
      page_outcome_t got;
      page_outcome_t want;
      bit            same;
      got.slot = data[3:0];
      got.evicted = data[19:4];
      got.fault_total = data[51:20];
      got.reference_total = data[83:52];
      got.hit = user[0];
      got.fault = user[1];
      got.filled = user[2];
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing outstanding: hit=%0b fault=%0b filled=%0b slot=%0d",
                   $realtime, got.hit, got.fault, got.filled, got.slot);
        end
        return;
      end
      want = expected_outcomes.pop_front();
      hits_seen += want.hit;
      fills_seen += want.filled;
      faults_seen += want.fault;
      same = (got.hit == want.hit) && (got.fault == want.fault) &&
             (got.filled == want.filled) && (got.slot == want.slot) &&
             (got.evicted == want.evicted) && (got.fault_total == want.fault_total) &&
             (got.reference_total == want.reference_total);
      if (!same) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: outcome mismatch", $realtime);
          $display("  expected hit=%0b fault=%0b filled=%0b slot=%0d evicted=%h faults=%0d refs=%0d",
                   want.hit, want.fault, want.filled, want.slot, want.evicted,
                   want.fault_total, want.reference_total);
          $display("  actual   hit=%0b fault=%0b filled=%0b slot=%0d evicted=%h faults=%0d refs=%0d",
                   got.hit, got.fault, got.filled, got.slot, got.evicted,
                   got.fault_total, got.reference_total);
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lrupr_pkg::*;
  import lru_tb_pkg::*;

  localparam int LONG_HOLD = 80;
  localparam int PHASES = 14;
  localparam int ITEMS_PER_PHASE = 131;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [2:0]  m_tuser;

  frame_table_model tables = new();

  int          send_gap_pct = 0;
  int          recv_gap_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned limits_written = 0;
  int unsigned pages_sent = 0;
  port_page_t  page_pool[20];
  int          pool_size = 1;

  lru_page_replacement uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < recv_gap_pct) begin
        stall_left = $urandom_range(1, 12) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tables.check_outcome(m_tdata, m_tuser);
    end
  end

  task automatic send_page(input port_page_t pg);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= pg;
    do @(posedge clk); while (!s_tready);
    tables.note_reference(pg);
    pages_sent++;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tables.pending() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input cfg_t value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tables.set_limit(value);
    limits_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly references to a working set near the frame count, so hits, fills
  // and faults all show up; the rest spreads over the whole page space.
  function automatic port_page_t pick_page();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      return page_pool[$urandom_range(0, pool_size - 1)];
    end else if (roll < 95) begin
      return port_page_t'($urandom);
    end else if (roll < 98) begin
      return port_page_t'(1) << $urandom_range(0, 15);
    end
    return ~(port_page_t'(1) << $urandom_range(0, 15));
  endfunction

  initial begin
    cfg_t phase_limits[PHASES];
    phase_limits = '{5'd1, 5'd3, 5'd0, 5'd2, 5'd6, 5'd10, 5'd5, 5'd16,
                     5'd31, 5'd4, 5'd12, 5'd24, 5'd8, 5'd16};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, hits, fills, then a limit of zero (which also lowers
    // the limit under the filled frames), a limit past the table size with
    // refilling, and one more lower and raise.
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0001);
    send_page(16'h0000);
    send_page(16'hFFFF);
    write_limit(5'd0);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'hFFFF);
    send_page(16'h1234);
    write_limit(5'd31);
    send_page(16'h8000);
    send_page(16'h7FFF);
    send_page(16'h0002);
    write_limit(5'd1);
    send_page(16'hAAAA);
    send_page(16'h5555);
    write_limit(5'd2);
    send_page(16'h0003);
    send_page(16'h5555);
    send_page(16'h0004);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_limit(phase_limits[ph]);
      pool_size = tables.managed_frames() + $urandom_range(0, 4);
      for (int k = 0; k < pool_size; k++) begin
        page_pool[k] = port_page_t'($urandom);
      end
      if (ph == PHASES - 1) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end else begin
        send_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        recv_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 3 && n == 30) begin
          hold_request = 1'b1;
        end
        if (ph == 5 && n == ITEMS_PER_PHASE / 2) begin
          drain_results();
        end
        send_page(pick_page());
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d page references across %0d frame-limit writes (0 through 31).",
             pages_sent, limits_written);
    $display("Outcomes checked: %0d hits, %0d fills, %0d faults, with a %0d-cycle hold-off.",
             tables.hits_seen, tables.fills_seen, tables.faults_seen, LONG_HOLD);
    if (tables.mismatches == 0 && tables.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
